// ===== design/bbi2c_pkg.sv =====
`timescale 1ns / 1ps
package bbi2c_pkg;
  localparam int BufferDepth = 16;
  localparam int PauseTicks = 3;
  localparam int IdlePauseFactor = 10;
  localparam int MaxSubs = 4;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OK = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic CFG_ADDR = 1'b0;
  localparam logic CFG_COMPAT = 1'b1;

  typedef enum logic [4:0] {
    B_IDLE, B_PAUSE, B_RECLOCK0, B_RECLOCK1, B_RACK0, B_RACK1, B_RACK2,
    B_WACK0, B_WACK1, B_WACK2, B_START0, B_START1, B_SCL_LOW,
    B_SAMPLE0, B_SAMPLE1, B_SAMPLE2, B_STOP0, B_STOP1
  } bus_phase_t;

  typedef enum logic [2:0] {
    T_NONE, T_WAITING, T_START, T_TRANSMIT, T_WRITE_ACK, T_READ_ACK, T_STOP
  } xfer_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic       scl_line;
    logic       sda_line;
    logic [3:0] load_index;
    logic [7:0] byte_value;
    logic       read_mode;
    logic [4:0] write_count;
    logic [4:0] read_count;
  } item_t;

  typedef struct packed {
    logic       scl_release;
    logic       scl_pull_low;
    logic       sda_release;
    logic       sda_pull_low;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [3:0] read_index;
    logic [1:0] status;
    logic       busy_res;
    logic       start_rejected;
  } result_t;
endpackage

// ===== design/bbi2c_core.sv =====
`timescale 1ns / 1ps
module bbi2c_core
  import bbi2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [6:0] device_address,
  input  logic       compat_mode,
  output result_t    res
);

  bus_phase_t  bus_phase, bus_phase_next;
  xfer_phase_t transfer_phase, transfer_phase_next;
  logic [2:0] sub_index, sub_index_next, sub_total, sub_total_next;
  logic [4:0] bytes_done, bytes_done_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [3:0] bit_position, bit_position_next;
  logic [4:0] pause_left, pause_left_next;
  bus_phase_t pause_target, pause_target_next;
  logic [4:0] len0, len0_next, len1, len1_next;
  logic [1:0] outcome, outcome_next;
  logic [7:0] write_buffer [BufferDepth];
  logic [3:0] fetch_idx;
  logic [7:0] fetch_data;
  result_t r;

  function automatic logic [7:0] pick(input logic [2:0] si, input logic [6:0] da,
                                      input logic [7:0] buf_byte);
    logic [7:0] v;
    v = 8'd0;
    if (si == 3'd0) v = {da, 1'b0};
    else if (si == 3'd2) v = {da, 1'b1};
    else if (si == 3'd1) v = buf_byte;
    return v;
  endfunction

  always_comb begin
    logic       is_read;
    logic [4:0] size;
    logic       ends_stop;
    logic [4:0] bd1;
    logic [2:0] si;
    bus_phase_t gp_target;
    logic       gp;
    logic       fin;

    bus_phase_next = bus_phase;
    transfer_phase_next = transfer_phase;
    sub_index_next = sub_index;
    sub_total_next = sub_total;
    bytes_done_next = bytes_done;
    shift_byte_next = shift_byte;
    bit_position_next = bit_position;
    pause_left_next = pause_left;
    pause_target_next = pause_target;
    len0_next = len0;
    len1_next = len1;
    outcome_next = outcome;
    r = '0;
    gp = 1'b0;
    gp_target = B_IDLE;
    fin = 1'b0;
    fetch_idx = 4'd0;
    is_read = (sub_index == 3'd3);
    size = (sub_index == 3'd1) ? len0 : (sub_index == 3'd3) ? len1 : 5'd1;
    ends_stop = (sub_index == 3'd1) ? (compat_mode || sub_total == 3'd2)
                                    : (sub_index == 3'd3);
    bd1 = bytes_done + 5'd1;
    si = sub_index;

    case (item.action)
      ACT_TICK: begin
        case (bus_phase)
          B_IDLE: begin
            if (transfer_phase == T_WAITING && sub_index < sub_total) begin
              if (sub_index == 3'd1 || sub_index == 3'd3) begin
                transfer_phase_next = T_TRANSMIT;
                bus_phase_next = B_SCL_LOW;
              end else begin
                r.scl_release = 1'b1;
                r.sda_release = 1'b1;
                bus_phase_next = (sub_index == 3'd2 && compat_mode) ? B_RECLOCK0 : B_START0;
                transfer_phase_next = T_START;
              end
              bytes_done_next = 5'd0;
              fetch_idx = 4'd0;
              shift_byte_next = is_read ? 8'd0 : pick(si, device_address, fetch_data);
              bit_position_next = 4'd7;
            end
            if (sub_index >= sub_total) transfer_phase_next = T_NONE;
          end
          B_PAUSE: begin
            logic [4:0] pl;
            pl = (pause_left != 5'd0) ? pause_left - 5'd1 : 5'd0;
            pause_left_next = pl;
            if (pl == 5'd0) bus_phase_next = pause_target;
          end
          B_RECLOCK0: begin r.scl_pull_low = 1'b1; bus_phase_next = B_RECLOCK1; end
          B_RECLOCK1: begin r.scl_release = 1'b1; bus_phase_next = B_START0; end
          B_RACK0: begin r.scl_release = 1'b1; bus_phase_next = B_RACK1; end
          B_RACK1: if (item.scl_line) bus_phase_next = B_RACK2;
          B_RACK2: begin
            if (item.sda_line) begin
              outcome_next = ST_FAIL;
              bus_phase_next = B_STOP0;
              transfer_phase_next = T_STOP;
              sub_index_next = sub_total;
            end else begin
              r.scl_pull_low = 1'b1;
              if (bytes_done < size) begin
                transfer_phase_next = T_TRANSMIT;
                bus_phase_next = B_SCL_LOW;
              end else fin = 1'b1;
            end
          end
          B_WACK0: begin r.scl_release = 1'b1; bus_phase_next = B_WACK1; end
          B_WACK1: begin r.scl_pull_low = 1'b1; bus_phase_next = B_WACK2; end
          B_WACK2: begin
            r.sda_release = 1'b1;
            bus_phase_next = B_SCL_LOW;
            transfer_phase_next = T_TRANSMIT;
          end
          B_START0: begin
            if (item.sda_line) begin
              r.sda_pull_low = 1'b1;
              gp = 1'b1;
              gp_target = B_START1;
            end else bus_phase_next = B_RECLOCK0;
          end
          B_START1: begin
            r.scl_pull_low = 1'b1;
            gp = 1'b1;
            gp_target = B_SCL_LOW;
            transfer_phase_next = T_TRANSMIT;
          end
          B_SCL_LOW: begin
            case (transfer_phase)
              T_TRANSMIT: begin
                if (!is_read) begin
                  if (shift_byte[bit_position[2:0]]) r.sda_release = 1'b1;
                  else r.sda_pull_low = 1'b1;
                  bit_position_next = bit_position - 4'd1;
                end
                bus_phase_next = B_SAMPLE0;
              end
              T_WRITE_ACK: begin
                if (item.sda_line) begin
                  r.sda_pull_low = 1'b1;
                  bus_phase_next = B_WACK0;
                end
              end
              T_READ_ACK: begin
                r.sda_release = 1'b1;
                r.scl_pull_low = 1'b1;
                bus_phase_next = B_RACK0;
              end
              T_STOP: begin
                r.sda_pull_low = 1'b1;
                gp = 1'b1;
                gp_target = B_STOP0;
              end
              default: ;
            endcase
          end
          B_SAMPLE0: begin r.scl_release = 1'b1; bus_phase_next = B_SAMPLE1; end
          B_SAMPLE1: begin
            if (is_read) begin
              if (item.sda_line) shift_byte_next[bit_position[2:0]] = 1'b1;
              bit_position_next = bit_position - 4'd1;
            end
            bus_phase_next = B_SAMPLE2;
          end
          B_SAMPLE2: begin
            r.scl_pull_low = 1'b1;
            bus_phase_next = B_SCL_LOW;
            if (bit_position[3]) begin
              bytes_done_next = bd1;
              bit_position_next = 4'd7;
              if (!is_read) begin
                fetch_idx = bd1[3:0];
                if (bd1 < size) begin
                  shift_byte_next = (sub_index == 3'd1 && bd1 < 5'(BufferDepth))
                                    ? fetch_data : pick(si, device_address, 8'd0);
                end
                transfer_phase_next = T_READ_ACK;
              end else begin
                r.read_valid = 1'b1;
                r.read_byte = shift_byte;
                r.read_index = bytes_done[3:0];
                shift_byte_next = 8'd0;
                if (bd1 < size) transfer_phase_next = T_WRITE_ACK;
                else fin = 1'b1;
              end
            end
          end
          B_STOP0: begin r.scl_release = 1'b1; gp = 1'b1; gp_target = B_STOP1; end
          B_STOP1: begin
            r.sda_release = 1'b1;
            gp = 1'b1;
            gp_target = B_IDLE;
            transfer_phase_next = T_WAITING;
          end
          default: bus_phase_next = B_IDLE;
        endcase
        if (fin) begin
          sub_index_next = sub_index + 3'd1;
          if (sub_index_next >= sub_total) outcome_next = ST_OK;
          if (ends_stop) begin
            bus_phase_next = B_SCL_LOW;
            transfer_phase_next = T_STOP;
          end else begin
            bus_phase_next = B_IDLE;
            transfer_phase_next = T_WAITING;
          end
        end
        if (gp) begin
          if (compat_mode) begin
            bus_phase_next = B_PAUSE;
            pause_left_next = (gp_target == B_IDLE) ? 5'(IdlePauseFactor * PauseTicks)
                                                    : 5'(PauseTicks);
            pause_target_next = gp_target;
          end else bus_phase_next = gp_target;
        end
      end
      ACT_START: begin
        if (bus_phase != B_IDLE || sub_index < sub_total || item.write_count == 5'd0 ||
            item.write_count > 5'(BufferDepth) ||
            (item.read_mode && item.read_count == 5'd0)) begin
          r.start_rejected = 1'b1;
        end else begin
          len0_next = item.write_count;
          len1_next = item.read_mode ? item.read_count : 5'd0;
          sub_index_next = 3'd0;
          sub_total_next = item.read_mode ? 3'(MaxSubs) : 3'd2;
          outcome_next = ST_BUSY;
          transfer_phase_next = T_WAITING;
          bus_phase_next = B_IDLE;
        end
      end
      default: ;
    endcase
    r.status = outcome_next;
    r.busy_res = (bus_phase_next != B_IDLE) || (sub_index_next < sub_total_next);
  end

  assign fetch_data = write_buffer[fetch_idx];

  always_ff @(posedge clk) begin
    if (step && item.action == ACT_LOAD) write_buffer[item.load_index] <= item.byte_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_phase <= B_IDLE;
      transfer_phase <= T_NONE;
      sub_index <= 3'd0;
      sub_total <= 3'd0;
      bytes_done <= 5'd0;
      shift_byte <= 8'd0;
      bit_position <= 4'd7;
      pause_left <= 5'd0;
      pause_target <= B_IDLE;
      len0 <= 5'd0;
      len1 <= 5'd0;
      outcome <= ST_IDLE;
    end else if (step) begin
      bus_phase <= bus_phase_next;
      transfer_phase <= transfer_phase_next;
      sub_index <= sub_index_next;
      sub_total <= sub_total_next;
      bytes_done <= bytes_done_next;
      shift_byte <= shift_byte_next;
      bit_position <= bit_position_next;
      pause_left <= pause_left_next;
      pause_target <= pause_target_next;
      len0 <= len0_next;
      len1 <= len1_next;
      outcome <= outcome_next;
    end
  end

  assign res = r;

  a_sub_bound: assert property (@(posedge clk) disable iff (rst) sub_index <= sub_total)
    else $error("sub_index beyond sub_total");
  a_one_sda: assert property (@(posedge clk) disable iff (rst)
    !(res.sda_release && res.sda_pull_low)) else $error("SDA driven both ways");
  a_one_scl: assert property (@(posedge clk) disable iff (rst)
    !(res.scl_release && res.scl_pull_low)) else $error("SCL driven both ways");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (sub_total == 3'd0) |-> (outcome == ST_IDLE)) else $error("outcome without start");
endmodule

// ===== design/bitbang_i2c_master.sv =====
`timescale 1ns / 1ps
// Every accepted transaction yields its result in the next cycle
// from an output register. Throughput: one transaction per clock while results
// are taken; the input stalls only while a result waits unaccepted.
// Reset (rst, synchronous) puts the bus idle, clears counters and status and
// sets the address to 1 and compat mode off; the write buffer is not cleared.
module bitbang_i2c_master
  import bbi2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], scl_line, sda_line, load_index[3:0], byte_value[7:0],
  // read_mode, write_count[4:0], read_count[4:0], zero fill
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_release, scl_pull_low, sda_release, sda_pull_low, read_valid,
  // read_byte[7:0], read_index[3:0], status[1:0], busy_res, start_rejected
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  logic [6:0] device_address;
  logic       compat_mode;
  item_t      item;
  result_t    res;
  logic       step;

  assign s_tready = !m_tvalid || m_tready;
  assign step = s_tvalid && s_tready;
  assign item.action = s_tdata[1:0];
  assign item.scl_line = s_tdata[2];
  assign item.sda_line = s_tdata[3];
  assign item.load_index = s_tdata[7:4];
  assign item.byte_value = s_tdata[15:8];
  assign item.read_mode = s_tdata[16];
  assign item.write_count = s_tdata[21:17];
  assign item.read_count = s_tdata[26:22];

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 7'd1;
      compat_mode <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ADDR) device_address <= cfg_data;
      if (cfg_index == CFG_COMPAT) compat_mode <= cfg_data[0];
    end
  end

  bbi2c_core u_core (
    .clk(clk), .rst(rst), .step(step), .item(item),
    .device_address(device_address), .compat_mode(compat_mode), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (step) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) m_tdata <= {3'b000, res.start_rejected, res.busy_res, res.status,
                          res.read_index, res.read_byte, res.read_valid,
                          res.sda_pull_low, res.sda_release, res.scl_pull_low,
                          res.scl_release};
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("stalled while empty");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid) else $error("result lost");
endmodule

// ===== test/bitbang_i2c_master_test.sv =====
`timescale 1ns / 1ps
module bitbang_i2c_master_test;
  import bbi2c_pkg::*;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int RandomItems = 550;
  localparam int HoldCycles = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  bitbang_i2c_master dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the controller state.
  bus_phase_t  bus_ph;
  bus_phase_t  pause_to;
  xfer_phase_t xfer_ph;
  int          sub_idx;
  int          sub_tot;
  int          nbytes;
  int          bitpos;
  int          pause_cnt;
  int          len_wr;
  int          len_rd;
  logic [7:0]  shreg;
  logic [7:0]  wbuf [BufferDepth];
  logic [1:0]  outc;
  logic [6:0]  dev_addr;
  logic        compat;

  logic [20:0] pending_results [$];
  int          errors;
  int          accepted;
  bit          full_rate;
  bit          hold_done;

  function automatic logic [26:0] pack_item(logic [1:0] act, logic scl, logic sda,
                                            logic [3:0] li, logic [7:0] bv, logic rd,
                                            logic [4:0] wc, logic [4:0] rc);
    return {rc, wc, rd, bv, li, sda, scl, act};
  endfunction

  function automatic logic [20:0] bus_result(logic [1:0] st, logic bsy, logic rej);
    return {rej, bsy, st, 17'd0};
  endfunction

  function automatic bit ctrl_busy();
    return bus_ph != B_IDLE || sub_idx < sub_tot;
  endfunction

  function automatic int sub_size();
    if (sub_idx == 1) return len_wr;
    if (sub_idx == 3) return len_rd;
    return 1;
  endfunction

  function automatic logic [7:0] sub_byte(int k);
    if (sub_idx == 0) return {dev_addr, 1'b0};
    if (sub_idx == 2) return {dev_addr, 1'b1};
    if (sub_idx == 1 && k < BufferDepth) return wbuf[k];
    return 8'd0;
  endfunction

  function automatic void go_phase(bus_phase_t nxt);
    if (compat) begin
      bus_ph = B_PAUSE;
      pause_cnt = (nxt == B_IDLE) ? IdlePauseFactor * PauseTicks : PauseTicks;
      pause_to = nxt;
    end else begin
      bus_ph = nxt;
    end
  endfunction

  function automatic void finish_sub();
    bit stop;
    stop = (sub_idx == 1) ? (compat || sub_tot == 2) : (sub_idx == 3);
    sub_idx++;
    if (sub_idx >= sub_tot) outc = ST_OK;
    if (stop) begin
      bus_ph = B_SCL_LOW;
      xfer_ph = T_STOP;
    end else begin
      bus_ph = B_IDLE;
      xfer_ph = T_WAITING;
    end
  endfunction

  function automatic logic [20:0] predict_lines(logic [26:0] d);
    logic [1:0] act;
    logic       scl;
    logic       sda;
    logic [3:0] pins;
    logic       rv;
    logic [7:0] rb;
    logic [3:0] ri;
    logic       rej;
    int         pos;
    bit         rd_sub;
    act = d[1:0];
    scl = d[2];
    sda = d[3];
    pins = '0;
    rv = 1'b0;
    rb = '0;
    ri = '0;
    rej = 1'b0;
    rd_sub = (sub_idx == 3);
    if (act == ACT_TICK) begin
      case (bus_ph)
        B_IDLE: begin
          if (xfer_ph == T_WAITING && sub_idx < sub_tot) begin
            if (sub_idx == 1 || sub_idx == 3) begin
              xfer_ph = T_TRANSMIT;
              bus_ph = B_SCL_LOW;
            end else begin
              pins[0] = 1;
              pins[2] = 1;
              bus_ph = (sub_idx == 2 && compat) ? B_RECLOCK0 : B_START0;
              xfer_ph = T_START;
            end
            nbytes = 0;
            shreg = rd_sub ? 8'd0 : sub_byte(0);
            bitpos = 7;
          end
          if (sub_idx >= sub_tot) xfer_ph = T_NONE;
        end
        B_PAUSE: begin
          if (pause_cnt > 0) pause_cnt--;
          if (pause_cnt == 0) bus_ph = pause_to;
        end
        B_RECLOCK0: begin
          pins[1] = 1;
          bus_ph = B_RECLOCK1;
        end
        B_RECLOCK1: begin
          pins[0] = 1;
          bus_ph = B_START0;
        end
        B_RACK0: begin
          pins[0] = 1;
          bus_ph = B_RACK1;
        end
        B_RACK1: begin
          if (scl) bus_ph = B_RACK2;
        end
        B_RACK2: begin
          if (sda) begin
            outc = ST_FAIL;
            bus_ph = B_STOP0;
            xfer_ph = T_STOP;
            sub_idx = sub_tot;
          end else begin
            pins[1] = 1;
            if (nbytes < sub_size()) begin
              xfer_ph = T_TRANSMIT;
              bus_ph = B_SCL_LOW;
            end else begin
              finish_sub();
            end
          end
        end
        B_WACK0: begin
          pins[0] = 1;
          bus_ph = B_WACK1;
        end
        B_WACK1: begin
          pins[1] = 1;
          bus_ph = B_WACK2;
        end
        B_WACK2: begin
          pins[2] = 1;
          bus_ph = B_SCL_LOW;
          xfer_ph = T_TRANSMIT;
        end
        B_START0: begin
          if (sda) begin
            pins[3] = 1;
            go_phase(B_START1);
          end else begin
            bus_ph = B_RECLOCK0;
          end
        end
        B_START1: begin
          pins[1] = 1;
          go_phase(B_SCL_LOW);
          xfer_ph = T_TRANSMIT;
        end
        B_SCL_LOW: begin
          if (xfer_ph == T_TRANSMIT) begin
            if (!rd_sub) begin
              if (shreg[bitpos[2:0]]) pins[2] = 1;
              else pins[3] = 1;
              bitpos--;
            end
            bus_ph = B_SAMPLE0;
          end else if (xfer_ph == T_WRITE_ACK) begin
            if (sda) begin
              pins[3] = 1;
              bus_ph = B_WACK0;
            end
          end else if (xfer_ph == T_READ_ACK) begin
            pins[2] = 1;
            pins[1] = 1;
            bus_ph = B_RACK0;
          end else if (xfer_ph == T_STOP) begin
            pins[3] = 1;
            go_phase(B_STOP0);
          end
        end
        B_SAMPLE0: begin
          pins[0] = 1;
          bus_ph = B_SAMPLE1;
        end
        B_SAMPLE1: begin
          if (rd_sub) begin
            if (sda) shreg[bitpos[2:0]] = 1'b1;
            bitpos--;
          end
          bus_ph = B_SAMPLE2;
        end
        B_SAMPLE2: begin
          pins[1] = 1;
          bus_ph = B_SCL_LOW;
          if (bitpos < 0) begin
            pos = nbytes;
            nbytes = (nbytes + 1) & 31;
            bitpos = 7;
            if (!rd_sub) begin
              if (nbytes < sub_size()) shreg = sub_byte(nbytes);
              xfer_ph = T_READ_ACK;
            end else begin
              rv = 1'b1;
              rb = shreg;
              ri = pos[3:0];
              shreg = '0;
              if (nbytes < sub_size()) xfer_ph = T_WRITE_ACK;
              else finish_sub();
            end
          end
        end
        B_STOP0: begin
          pins[0] = 1;
          go_phase(B_STOP1);
        end
        B_STOP1: begin
          pins[2] = 1;
          go_phase(B_IDLE);
          xfer_ph = T_WAITING;
        end
        default: bus_ph = B_IDLE;
      endcase
    end else if (act == ACT_LOAD) begin
      wbuf[d[7:4]] = d[15:8];
    end else if (act == ACT_START) begin
      if (ctrl_busy() || d[21:17] == 0 || d[21:17] > BufferDepth ||
          (d[16] && d[26:22] == 0)) begin
        rej = 1'b1;
      end else begin
        len_wr = int'(d[21:17]);
        len_rd = d[16] ? int'(d[26:22]) : 0;
        sub_idx = 0;
        sub_tot = d[16] ? MaxSubs : 2;
        outc = ST_BUSY;
        xfer_ph = T_WAITING;
        bus_ph = B_IDLE;
      end
    end
    return {rej, ctrl_busy(), outc, ri, rb, rv, pins};
  endfunction

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Result checker: every output transaction is compared with the oldest queued expected result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", m_tdata));
      end else begin
        logic [20:0] want;
        want = pending_results.pop_front();
        if (m_tdata[3:0] !== want[3:0])
          report($sformatf("line actions %b, expected %b", m_tdata[3:0], want[3:0]));
        if (m_tdata[4] !== want[4])
          report($sformatf("read_valid %b, expected %b", m_tdata[4], want[4]));
        if (m_tdata[12:5] !== want[12:5])
          report($sformatf("read_byte %h, expected %h", m_tdata[12:5], want[12:5]));
        if (m_tdata[16:13] !== want[16:13])
          report($sformatf("read_index %0d, expected %0d", m_tdata[16:13], want[16:13]));
        if (m_tdata[18:17] !== want[18:17])
          report($sformatf("status %0d, expected %0d", m_tdata[18:17], want[18:17]));
        if (m_tdata[19] !== want[19])
          report($sformatf("busy %b, expected %b", m_tdata[19], want[19]));
        if (m_tdata[20] !== want[20])
          report($sformatf("start_rejected %b, expected %b", m_tdata[20], want[20]));
      end
    end
  end

  // Receiver: random back-pressure (ready held high in the full-rate phase) with one long hold so the input stalls.
  initial begin
    int r;
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && accepted > 300) begin
        m_tready <= 0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1;
      end else if (full_rate) begin
        m_tready <= 1;
        @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1;
          @(negedge clk);
        end else begin
          m_tready <= 0;
          repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(negedge clk);
        end
      end
    end
  end

  task automatic send(logic [26:0] d, bit typed, logic [20:0] typed_res);
    int gap;
    logic [20:0] p;
    gap = 0;
    if (!full_rate) begin
      gap = $urandom_range(0, 99);
      gap = gap < 65 ? 0 : (gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30));
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {5'd0, d};
    do @(posedge clk); while (!s_tready);
    p = predict_lines(d);
    pending_results.push_back(typed ? typed_res : p);
    accepted++;
  endtask

  task automatic quiet_input();
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  // Builds a tick whose line levels mostly let the transfer advance.
  function automatic logic [26:0] bus_tick();
    logic scl;
    logic sda;
    scl = $urandom_range(0, 9) != 0;
    if (bus_ph == B_RACK2) sda = $urandom_range(0, 11) == 0;
    else if (bus_ph == B_START0) sda = $urandom_range(0, 5) != 0;
    else sda = 1'($urandom_range(0, 1));
    return pack_item(ACT_TICK, scl, sda, 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
  endfunction

  task automatic run_until_idle();
    while (ctrl_busy()) begin
      if ($urandom_range(0, 19) == 0)
        send(pack_item(2'($urandom_range(1, 3)), 1'($urandom), 1'($urandom),
                       4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       1'($urandom), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31))), 0, '0);
      else
        send(bus_tick(), 0, '0);
    end
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    quiet_input();
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CFG_ADDR) dev_addr = val;
    else compat = val[0];
  endtask

  typedef struct {
    logic [26:0] item;
    bit          typed;
    logic [20:0] res;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    logic [20:0] idle_res;
    logic [4:0] wc;
    logic [4:0] rc;
    int target;
    int r;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = '0;
    rst = 1;
    errors = 0;
    accepted = 0;
    full_rate = 0;
    hold_done = 0;
    bus_ph = B_IDLE;
    pause_to = B_IDLE;
    xfer_ph = T_NONE;
    sub_idx = 0;
    sub_tot = 0;
    nbytes = 0;
    bitpos = 7;
    pause_cnt = 0;
    len_wr = 0;
    len_rd = 0;
    shreg = '0;
    outc = ST_IDLE;
    dev_addr = 7'd1;
    compat = 0;
    repeat (12) @(negedge clk);
    rst <= 0;

    idle_res = bus_result(ST_IDLE, 1'b0, 1'b0);
    for (int i = 0; i < BufferDepth; i++)
      rows.push_back('{pack_item(ACT_LOAD, 1'b0, 1'b0, 4'(i), 8'(i * 17), 1'b0, 5'd0, 5'd0),
                       1, idle_res});
    rows.push_back('{pack_item(ACT_NOP, 1, 1, 4'hF, 8'hFF, 1, 5'd31, 5'd31), 1, idle_res});
    rows.push_back('{pack_item(ACT_TICK, 1, 1, 0, 0, 0, 0, 0), 1, idle_res});
    rows.push_back('{pack_item(ACT_START, 0, 0, 0, 0, 0, 5'd0, 5'd1),
                     1, bus_result(ST_IDLE, 0, 1)});
    rows.push_back('{pack_item(ACT_START, 0, 0, 0, 0, 0, 5'd17, 5'd1),
                     1, bus_result(ST_IDLE, 0, 1)});
    rows.push_back('{pack_item(ACT_START, 0, 0, 0, 0, 1, 5'd4, 5'd0),
                     1, bus_result(ST_IDLE, 0, 1)});
    rows.push_back('{pack_item(ACT_START, 0, 0, 0, 0, 1, 5'd16, 5'd17),
                     1, bus_result(ST_BUSY, 1, 0)});
    rows.push_back('{pack_item(ACT_START, 0, 0, 0, 0, 0, 5'd1, 5'd0),
                     1, bus_result(ST_BUSY, 1, 1)});
    rows.push_back('{pack_item(ACT_TICK, 1, 1, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{pack_item(ACT_TICK, 1, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{pack_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].res);
    run_until_idle();

    target = accepted;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_ADDR, 7'd127);
          write_reg(CFG_COMPAT, 7'd1);
        end
        1: begin
          write_reg(CFG_ADDR, 7'd0);
          write_reg(CFG_COMPAT, 7'd0);
        end
        2: write_reg(CFG_ADDR, 7'd1);
        default: begin
          write_reg(CFG_ADDR, 7'($urandom_range(1, 126)));
          write_reg(CFG_COMPAT, 7'd1);
        end
      endcase
      full_rate = (ph == 1);
      target += RandomItems / 4;
      while (accepted < target) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          repeat ($urandom_range(0, 2))
            send(pack_item(ACT_LOAD, 1'($urandom), 1'($urandom), 4'($urandom_range(0, 15)),
                           8'($urandom_range(0, 255)), 1'($urandom),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))), 0, '0);
          wc = $urandom_range(0, 19) == 0 ? 5'(BufferDepth) : 5'($urandom_range(1, 3));
          r = $urandom_range(0, 39);
          rc = r == 0 ? 5'd16 : (r == 1 ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1, 3)));
          send(pack_item(ACT_START, 1'($urandom), 1'($urandom), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), wc, rc),
               0, '0);
        end else begin
          send(pack_item(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                         1'($urandom), 5'($urandom_range(0, 31)),
                         5'($urandom_range(0, 31))), 0, '0);
        end
        run_until_idle();
      end
    end

    quiet_input();
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
